### hdl/phsq_pkg.sv
// Shared types and constants for the prefix hash substring query block.
// Holds field widths, stream packing offsets, Barrett constants and FSM/struct types.
// No dependencies.
package phsq_pkg;

    localparam int HASH_W = 30;
    localparam int LEN_W  = 11;
    localparam int BYTE_W = 8;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    localparam int LEFT_LSB   = BYTE_W;
    localparam int RIGHT_LSB  = BYTE_W + LEN_W;
    localparam int IN_PACK_W  = BYTE_W + 2 * LEN_W;
    localparam int S_TDATA_W  = ((IN_PACK_W + 7) / 8) * 8;
    localparam int OUT_PACK_W = HASH_W + LEN_W;
    localparam int M_TDATA_W  = ((OUT_PACK_W + 7) / 8) * 8;

    localparam int MAX_LEN_DEF = 1024;

    localparam logic [HASH_W-1:0] HASH_MOD   = 30'd1000000007;
    localparam logic [HASH_W-1:0] BASE_RESET = 30'd179;

    // Barrett reduction: mu = floor(2^(2*HASH_W) / p)
    localparam int MUL_W  = HASH_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int RED_W  = HASH_W + 2;
    localparam logic [63:0] BARRETT_MU_FULL = (64'd1 << (2 * HASH_W)) / 64'd1000000007;
    localparam logic [MUL_W-1:0] BARRETT_MU = BARRETT_MU_FULL[MUL_W-1:0];

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR,
        FN_APPEND,
        FN_POP,
        FN_QUERY
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_BAD_RANGE
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_APP_RD,
        S_APP_MUL,
        S_APP_WAIT,
        S_Q_RDTOP,
        S_Q_RDSUB,
        S_Q_GOTSUB,
        S_Q_POW,
        S_Q_WMUL,
        S_Q_SQ,
        S_Q_WSQ,
        S_Q_FIN,
        S_Q_WFIN,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_AB,
        PH_MU,
        PH_QP,
        PH_SUB,
        PH_FIX
    } t_mm_phase;

    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic [BYTE_W-1:0] addend;
    } t_mm_req;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] res;
    } t_mm_rsp;

endpackage

### hdl/phsq_mem.sv
// Prefix hash store: single write port, single read port, registered read data.
// Depends on nothing; widths come from parameters.
module phsq_mem #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 30,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/phsq_modmul.sv
// Multi-cycle (a*b + addend) mod p unit with one shared 31x31 multiplier.
// Barrett reduction over three multiplier passes; depends on phsq_pkg.
module phsq_modmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  phsq_pkg::t_mm_req i_req,
    output phsq_pkg::t_mm_rsp o_rsp
);
    import phsq_pkg::*;

    t_mm_phase r_phase, n_phase;

    logic [MUL_W-1:0]  r_ma, r_mb;
    logic [BYTE_W-1:0] r_add;
    logic [PROD_W-1:0] r_x, r_prod;
    logic [RED_W-1:0]  r_r;
    logic              r_done;
    logic [HASH_W-1:0] r_res;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [RED_W-1:0]  mod_one, mod_two, fixed;

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (i_req.valid) n_phase = PH_AB;
            end
            PH_AB:   n_phase = PH_MU;
            PH_MU:   n_phase = PH_QP;
            PH_QP:   n_phase = PH_SUB;
            PH_SUB:  n_phase = PH_FIX;
            PH_FIX:  n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_comb begin
        case (r_phase)
            PH_MU: begin
                mul_a = r_x[2*HASH_W-1:HASH_W-1];
                mul_b = BARRETT_MU;
            end
            PH_QP: begin
                mul_a = r_prod[PROD_W-1:HASH_W+1];
                mul_b = MUL_W'(HASH_MOD);
            end
            default: begin
                mul_a = r_ma;
                mul_b = r_mb;
            end
        endcase
    end

    assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign mod_one = RED_W'(HASH_MOD);
    assign mod_two = RED_W'(HASH_MOD) << 1;

    // Barrett remainder is below 3p
    always_comb begin
        if (r_r >= mod_two) begin
            fixed = r_r - mod_two;
        end else if (r_r >= mod_one) begin
            fixed = r_r - mod_one;
        end else begin
            fixed = r_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == PH_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            PH_IDLE: begin
                if (i_req.valid) begin
                    r_ma  <= MUL_W'(i_req.a);
                    r_mb  <= MUL_W'(i_req.b);
                    r_add <= i_req.addend;
                end
            end
            PH_AB:   r_x    <= mul_p + PROD_W'(r_add);
            PH_MU:   r_prod <= mul_p;
            PH_QP:   r_prod <= mul_p;
            PH_SUB:  r_r    <= r_x[RED_W-1:0] - r_prod[RED_W-1:0];
            PH_FIX:  r_res  <= fixed[HASH_W-1:0];
            default: r_res  <= r_res;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    a_req_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> r_phase == PH_IDLE)
        else $error("modmul request while busy");

    a_res_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_res < HASH_MOD)
        else $error("modmul result not reduced");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("modmul done longer than one cycle");

endmodule

### hdl/prefix_hash_substring_query.sv
// Prefix polynomial hash store with range queries (hash mod 1000000007).
// Slave stream: tuser = func; tdata = byte_in, range_left, range_right (LSB first).
// Master stream: tuser = status; tdata = hash_out, length_out (LSB first).
// Config: i_cfg_we/i_cfg_wdata write hash_base (reset 179); write only with no item in flight.
// One item at a time; s_axis_tready is high only while the controller is idle.
// Work from accept to result in the output register:
//   clear, pop, full append, bad or empty range: decode only
//   append: one store read, one modular multiply
//   query [0,r): one store read
//   query [l,r) with l > 0: two store reads, then base^(r-l) by square and multiply
//   (a multiply per one bit, a squaring per higher bit), one final multiply.
// Each modular multiply, from request to result, runs on one shared 31x31
// multiplier (product, two Barrett passes, subtract, final correction).
// The next item can be accepted in the cycle after its predecessor reaches the output
// register; if the receiver stalls, a second finished result waits in the
// controller until the output register drains.
// Reset clears the length and the output valid and sets the base to 179; the store
// needs no clearing.
// Depends on phsq_pkg, phsq_mem, phsq_modmul.
module prefix_hash_substring_query #(
    parameter int MAX_LEN = phsq_pkg::MAX_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // byte_in[7:0], range_left[18:8], range_right[29:19], zero pad
    input  logic [phsq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func[1:0]
    input  logic [phsq_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // hash_out[29:0], length_out[40:30], zero pad
    output logic [phsq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [phsq_pkg::STAT_W-1:0]    m_axis_tuser,
    input  logic                           i_cfg_we,
    input  logic [phsq_pkg::HASH_W-1:0]    i_cfg_wdata
);
    import phsq_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    t_state r_state, n_state;

    t_func             r_func;
    logic [BYTE_W-1:0] r_byte;
    logic [LEN_W-1:0]  r_left, r_right, r_exp;
    logic [CNT_W-1:0]  r_len;
    logic [HASH_W-1:0] r_base;
    logic [HASH_W-1:0] r_top, r_sub, r_acc, r_pw, r_hash;
    t_status           r_status;
    logic              r_m_valid;
    logic [HASH_W-1:0] r_m_hash;
    logic [LEN_W-1:0]  r_m_len;
    t_status           r_m_status;

    logic              in_xfer, out_free;
    logic [HASH_W-1:0] base_mod, diff;
    logic [CMP_W-1:0]  len_cmp, left_cmp, right_cmp, top_idx, sub_idx, prev_idx;
    logic              is_full, is_empty, bad_range;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    logic [HASH_W-1:0] mem_rdata;
    t_mm_req           mm_req;
    t_mm_rsp           mm_rsp;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;

    assign base_mod  = (r_base >= HASH_MOD) ? r_base - HASH_MOD : r_base;
    assign len_cmp   = CMP_W'(r_len);
    assign left_cmp  = CMP_W'(r_left);
    assign right_cmp = CMP_W'(r_right);
    assign top_idx   = right_cmp - CMP_W'(1);
    assign sub_idx   = left_cmp - CMP_W'(1);
    assign prev_idx  = len_cmp - CMP_W'(1);
    assign is_full   = (r_len == CNT_W'(MAX_LEN));
    assign is_empty  = (r_len == '0);
    assign bad_range = (r_left > r_right) || (right_cmp > len_cmp);
    assign diff      = (r_top < mm_rsp.res) ? r_top + HASH_MOD - mm_rsp.res
                                            : r_top - mm_rsp.res;
    assign mem_we    = (r_state == S_APP_WAIT) && mm_rsp.done;

    phsq_mem #(
        .DEPTH  (MAX_LEN),
        .WIDTH  (HASH_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_len[ADDR_W-1:0]),
        .i_wdata (mm_rsp.res),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    phsq_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (r_func)
                    FN_APPEND: n_state = is_full ? S_OUT : S_APP_RD;
                    FN_QUERY:  n_state = (bad_range || r_left == r_right) ? S_OUT : S_Q_RDTOP;
                    default:   n_state = S_OUT;
                endcase
            end
            S_APP_RD:   n_state = S_APP_MUL;
            S_APP_MUL:  n_state = S_APP_WAIT;
            S_APP_WAIT: begin
                if (mm_rsp.done) n_state = S_OUT;
            end
            S_Q_RDTOP:  n_state = S_Q_RDSUB;
            S_Q_RDSUB:  n_state = S_Q_GOTSUB;
            S_Q_GOTSUB: n_state = (r_left == '0) ? S_OUT : S_Q_POW;
            S_Q_POW:    n_state = r_exp[0] ? S_Q_WMUL : S_Q_SQ;
            S_Q_WMUL: begin
                if (mm_rsp.done) n_state = S_Q_SQ;
            end
            S_Q_SQ:     n_state = (r_exp[LEN_W-1:1] == '0) ? S_Q_FIN : S_Q_WSQ;
            S_Q_WSQ: begin
                if (mm_rsp.done) n_state = S_Q_POW;
            end
            S_Q_FIN:    n_state = S_Q_WFIN;
            S_Q_WFIN: begin
                if (mm_rsp.done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        mm_req        = '0;
        case (r_state)
            S_APP_RD:  mem_raddr = prev_idx[ADDR_W-1:0];
            S_Q_RDTOP: mem_raddr = top_idx[ADDR_W-1:0];
            default:   mem_raddr = sub_idx[ADDR_W-1:0];
        endcase
        case (r_state)
            S_APP_MUL: begin
                mm_req.valid  = 1'b1;
                mm_req.a      = is_empty ? '0 : mem_rdata;
                mm_req.b      = base_mod;
                mm_req.addend = r_byte;
            end
            S_Q_POW: begin
                mm_req.valid = r_exp[0];
                mm_req.a     = r_acc;
                mm_req.b     = r_pw;
            end
            S_Q_SQ: begin
                mm_req.valid = (r_exp[LEN_W-1:1] != '0);
                mm_req.a     = r_pw;
                mm_req.b     = r_pw;
            end
            S_Q_FIN: begin
                mm_req.valid = 1'b1;
                mm_req.a     = r_sub;
                mm_req.b     = r_acc;
            end
            default: mm_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_base    <= BASE_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (r_state == S_DECODE && r_func == FN_CLEAR) begin
                r_len <= '0;
            end else if (r_state == S_DECODE && r_func == FN_POP && !is_empty) begin
                r_len <= r_len - CNT_W'(1);
            end else if (mem_we) begin
                r_len <= r_len + CNT_W'(1);
            end
            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_func   <= t_func'(s_axis_tuser);
                    r_byte   <= s_axis_tdata[BYTE_W-1:0];
                    r_left   <= s_axis_tdata[LEFT_LSB +: LEN_W];
                    r_right  <= s_axis_tdata[RIGHT_LSB +: LEN_W];
                    r_hash   <= '0;
                    r_status <= ST_OK;
                end
            end
            S_DECODE: begin
                r_exp <= r_right - r_left;
                case (r_func)
                    FN_APPEND: begin
                        if (is_full) r_status <= ST_FULL;
                    end
                    FN_POP: begin
                        if (is_empty) r_status <= ST_EMPTY;
                    end
                    FN_QUERY: begin
                        if (bad_range) r_status <= ST_BAD_RANGE;
                    end
                    default: r_status <= ST_OK;
                endcase
            end
            S_APP_WAIT: begin
                if (mm_rsp.done) r_hash <= mm_rsp.res;
            end
            S_Q_RDSUB: r_top <= mem_rdata;
            S_Q_GOTSUB: begin
                r_sub <= mem_rdata;
                r_acc <= HASH_W'(1);
                r_pw  <= base_mod;
                if (r_left == '0) r_hash <= r_top;
            end
            S_Q_WMUL: begin
                if (mm_rsp.done) r_acc <= mm_rsp.res;
            end
            S_Q_SQ: r_exp <= r_exp >> 1;
            S_Q_WSQ: begin
                if (mm_rsp.done) r_pw <= mm_rsp.res;
            end
            S_Q_WFIN: begin
                if (mm_rsp.done) r_hash <= diff;
            end
            S_OUT: begin
                if (out_free) begin
                    r_m_hash   <= r_hash;
                    r_m_len    <= len_cmp[LEN_W-1:0];
                    r_m_status <= r_status;
                end
            end
            default: r_hash <= r_hash;
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_m_len, r_m_hash});
    assign m_axis_tuser  = r_m_status;

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CNT_W'(MAX_LEN))
        else $error("held length beyond store depth");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !is_full)
        else $error("store write while full");

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == S_DECODE)
        else $error("accepted transfer not decoded");

endmodule

### bench/tb_prefix_hash_substring_query.sv
// Self-checking testbench for prefix_hash_substring_query: stream stimulus, a prefix hash
// predictor with its own store, length and base, and an in-order result scoreboard.
// Depends on phsq_pkg and the prefix_hash_substring_query RTL.
module tb_prefix_hash_substring_query;
    timeunit 1ns;
    timeprecision 1ps;

    import phsq_pkg::*;

    localparam int              STORE_DEPTH   = MAX_LEN_DEF;
    localparam longint unsigned MOD_P         = HASH_MOD;
    localparam int              SETTLE_CYCLES = 8;
    localparam int              TAIL_CYCLES   = 250;
    localparam int              DRAIN_LIMIT   = 200000;
    localparam int              PRINT_LIMIT   = 40;

    typedef struct {
        logic [HASH_W-1:0] digest;
        logic [LEN_W-1:0]  held;
        t_status           status;
    } t_query_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [FUNC_W-1:0]    s_axis_tuser  = FN_CLEAR;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]    m_axis_tuser;
    logic                 i_cfg_we      = 1'b0;
    logic [HASH_W-1:0]    i_cfg_wdata   = '0;

    // predictor state
    logic [HASH_W-1:0] model_prefix [STORE_DEPTH];
    int                model_len  = 0;
    logic [HASH_W-1:0] model_base = BASE_RESET;

    t_query_result pending_results [$];
    int            error_count    = 0;
    int            result_count   = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            stall_cycles   = 0;

    prefix_hash_substring_query u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #50_000_000;
        $display("prefix_hash_substring_query regression: fail");
        $finish;
    end

    function automatic longint unsigned mul_mod_p(longint unsigned a, longint unsigned b);
        return (a * b) % MOD_P;
    endfunction

    function automatic longint unsigned pow_mod_p(longint unsigned x, int unsigned e);
        longint unsigned acc;
        acc = 1;
        x = x % MOD_P;
        while (e != 0) begin
            if (e[0]) begin
                acc = mul_mod_p(acc, x);
            end
            x = mul_mod_p(x, x);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Updates the predicted store for one accepted transfer and returns its result.
    function automatic t_query_result apply_hash_op(t_func fn, logic [BYTE_W-1:0] byte_v,
                                                    logic [LEN_W-1:0] lft, logic [LEN_W-1:0] rgt);
        t_query_result   res;
        longint unsigned eff_base;
        longint unsigned prev;
        longint unsigned top;
        longint unsigned sub;
        res.digest = '0;
        res.status = ST_OK;
        eff_base   = model_base;
        eff_base   = eff_base % MOD_P;
        case (fn)
            FN_CLEAR: begin
                model_len = 0;
            end
            FN_APPEND: begin
                if (model_len >= STORE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    prev = (model_len != 0) ? model_prefix[model_len - 1] : 0;
                    res.digest = HASH_W'((prev * eff_base + byte_v) % MOD_P);
                    model_prefix[model_len] = res.digest;
                    model_len++;
                end
            end
            FN_POP: begin
                if (model_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    model_len--;
                end
            end
            default: begin
                if (lft > rgt || rgt > model_len) begin
                    res.status = ST_BAD_RANGE;
                end else if (lft != rgt) begin
                    top = model_prefix[rgt - 1];
                    if (lft != 0) begin
                        sub = mul_mod_p(model_prefix[lft - 1], pow_mod_p(eff_base, rgt - lft));
                        res.digest = HASH_W'((top + MOD_P - sub) % MOD_P);
                    end else begin
                        res.digest = HASH_W'(top);
                    end
                end
            end
        endcase
        res.held = LEN_W'(model_len);
        return res;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $time, result_count, what, got, want);
        end
    endtask

    // receiver: random stalls, plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (stall_cycles > 0) begin
            m_axis_tready <= 1'b0;
            stall_cycles  = stall_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_query_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, hash", m_axis_tdata[HASH_W-1:0], 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[HASH_W-1:0] !== want.digest) begin
                    report_mismatch("hash", m_axis_tdata[HASH_W-1:0], want.digest);
                end
                if (m_axis_tdata[HASH_W+LEN_W-1:HASH_W] !== want.held) begin
                    report_mismatch("length", m_axis_tdata[HASH_W+LEN_W-1:HASH_W], want.held);
                end
                if (m_axis_tuser !== want.status) begin
                    report_mismatch("status", m_axis_tuser, want.status);
                end
            end
            result_count++;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_op(t_func fn, logic [BYTE_W-1:0] byte_v,
                           logic [LEN_W-1:0] lft, logic [LEN_W-1:0] rgt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {{(S_TDATA_W - IN_PACK_W){1'b0}}, rgt, lft, byte_v};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.insert(pending_results.size(), apply_hash_op(fn, byte_v, lft, rgt));
        @(negedge i_clk);
    endtask

    task automatic send_query(int lft, int rgt);
        send_op(FN_QUERY, BYTE_W'($urandom), LEN_W'(lft), LEN_W'(rgt));
    endtask

    task automatic send_append(logic [BYTE_W-1:0] byte_v);
        send_op(FN_APPEND, byte_v, LEN_W'($urandom), LEN_W'($urandom));
    endtask

    task automatic send_simple(t_func fn);
        send_op(fn, BYTE_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_base(logic [HASH_W-1:0] value);
        wait_all_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_base  = value;
        @(negedge i_clk);
    endtask

    // Random clears, appends and pops; mostly well-formed queries inside the held string, some garbage ranges.
    task automatic send_random_op();
        int pick;
        int rgt;
        int lft;
        pick = $urandom_range(99);
        if (pick < 4) begin
            send_simple(FN_CLEAR);
        end else if (pick < 48) begin
            send_append(BYTE_W'($urandom));
        end else if (pick < 60) begin
            send_simple(FN_POP);
        end else if (pick < 90) begin
            rgt = $urandom_range(model_len);
            lft = $urandom_range(rgt);
            send_query(lft, rgt);
        end else if (pick < 94) begin
            send_query(0, model_len);
        end else begin
            send_query($urandom_range(2047), $urandom_range(2047));
        end
    endtask

    task automatic test_empty_store();
        send_simple(FN_POP);
        send_query(0, 0);
        send_query(0, 1);
        send_query(2047, 2047);
        send_append(8'h00);
        send_append(8'hFF);
        send_query(0, 2);
        send_query(1, 2);
        send_query(1, 1);
        send_query(2, 1);
        send_query(0, 3);
        send_simple(FN_POP);
        send_query(0, 1);
        send_simple(FN_CLEAR);
        send_simple(FN_POP);
        send_query(0, 0);
    endtask

    task automatic test_full_store();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_simple(FN_CLEAR);
        repeat (STORE_DEPTH) send_append(BYTE_W'($urandom));
        send_append(8'hA5);
        send_query(0, STORE_DEPTH);
        send_query(1, STORE_DEPTH);
        send_query(STORE_DEPTH - 1, STORE_DEPTH);
        send_query(0, STORE_DEPTH + 1);
        send_query(1024, 1024);
        send_simple(FN_POP);
        send_append(8'hFF);
        send_query(513, 1024);
        send_simple(FN_CLEAR);
        wait_all_results();
    endtask

    task automatic test_base_extremes();
        logic [HASH_W-1:0] bases [5];
        bases = '{30'd0, 30'd1, HASH_MOD - 30'd1, HASH_MOD, {HASH_W{1'b1}}};
        foreach (bases[i]) begin
            write_base(bases[i]);
            send_simple(FN_CLEAR);
            send_append(BYTE_W'($urandom));
            send_append(BYTE_W'($urandom));
            send_query(0, 2);
            send_query(1, 2);
        end
    endtask

    task automatic test_random_phases();
        int                idle_sel  [4];
        int                stall_sel [4];
        logic [HASH_W-1:0] phase_base [4];
        idle_sel   = '{0, 74, 0, 26};
        stall_sel  = '{0, 0, 74, 26};
        phase_base = '{BASE_RESET, 30'd2, HASH_W'($urandom), HASH_MOD - 30'd1};
        foreach (idle_sel[i]) begin
            write_base(phase_base[i]);
            send_idle_pct  = idle_sel[i];
            recv_stall_pct = stall_sel[i];
            repeat (125) send_random_op();
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_all_results();
        stall_cycles = 400;
        repeat (16) send_random_op();
        // sender pauses here until the block has emptied
        wait_all_results();
        repeat (10) send_random_op();
        wait_all_results();
    endtask

    initial begin
        int guard;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_store();
        test_full_store();
        test_base_extremes();
        test_random_phases();
        test_output_backpressure();

        recv_stall_pct = 0;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results missing", pending_results.size(), 0);
        end

        if (error_count == 0) begin
            $display("prefix_hash_substring_query regression: pass");
        end else begin
            $display("prefix_hash_substring_query regression: fail");
        end
        $finish;
    end

endmodule
